[design/olex_pkg.sv]
// ----------------------------------------------------------------------------
// Operator token lexer package
// Shared types, character codes, token kinds and kind lookup functions.
// ----------------------------------------------------------------------------
package olex_pkg;

  // Position counter width and the width of positions on the result port.
  localparam int POS_BITS  = 16;
  localparam int OUT_POS_W = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;
  localparam int Q_AW   = $clog2(QDEPTH);

  // Character codes.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;

  // Token kinds as seen on the result port.
  typedef enum logic [4:0] {
    KIND_PLUS, KIND_PLUS_EQ, KIND_MINUS, KIND_MINUS_EQ, KIND_MUL, KIND_MUL_EQ,
    KIND_DIV, KIND_DIV_EQ, KIND_COMMA, KIND_SEMICOLON, KIND_COLON,
    KIND_LPAREN, KIND_RPAREN, KIND_LSQUARE, KIND_RSQUARE, KIND_LCURLY,
    KIND_RCURLY, KIND_LANGLE, KIND_RANGLE, KIND_DBL_LANGLE, KIND_DBL_RANGLE,
    KIND_LANGLE_EQ, KIND_RANGLE_EQ, KIND_DOT, KIND_NUMBER, KIND_STRING,
    KIND_IDENT, KIND_SPACE, KIND_EOF, KIND_ERROR
  } tok_kind_t;

  // Character classes produced by the front.
  typedef enum logic [3:0] {
    CLS_OTHER, CLS_PLUS, CLS_MINUS, CLS_STAR, CLS_SLASH, CLS_LT, CLS_GT,
    CLS_EQ, CLS_QUOTE, CLS_DIGIT, CLS_DOT, CLS_ALPHA, CLS_PUNCT
  } chr_class_t;

  // Lexer modes held by the back.
  typedef enum logic [3:0] {
    MODE_IDLE, MODE_PLUS, MODE_MINUS, MODE_STAR, MODE_SLASH, MODE_LT,
    MODE_GT, MODE_NUMBER, MODE_STRING, MODE_IDENT
  } lex_mode_t;

  // Port payloads.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [4:0]           token_kind;
    logic [OUT_POS_W-1:0] start_position;
    logic [OUT_POS_W-1:0] end_position;
    logic                 last_of_run;
  } out_item_t;

  // A classified character.
  typedef struct packed {
    chr_class_t cls;
    tok_kind_t  punct_kind;
    logic       eos;
  } cls_item_t;

  // Queue write and read sides.
  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } q_beat_t;

  // Kind of a pending operator that closes in its single form.
  function automatic tok_kind_t single_kind(lex_mode_t m);
    tok_kind_t k;
    k = KIND_PLUS;
    case (m)
      MODE_MINUS: k = KIND_MINUS;
      MODE_STAR:  k = KIND_MUL;
      MODE_SLASH: k = KIND_DIV;
      MODE_LT:    k = KIND_LANGLE;
      MODE_GT:    k = KIND_RANGLE;
      default:    k = KIND_PLUS;
    endcase
    return k;
  endfunction

  // Kind of a pending operator followed by an equals sign.
  function automatic tok_kind_t eq_kind(lex_mode_t m);
    tok_kind_t k;
    k = KIND_PLUS_EQ;
    case (m)
      MODE_MINUS: k = KIND_MINUS_EQ;
      MODE_STAR:  k = KIND_MUL_EQ;
      MODE_SLASH: k = KIND_DIV_EQ;
      MODE_LT:    k = KIND_LANGLE_EQ;
      MODE_GT:    k = KIND_RANGLE_EQ;
      default:    k = KIND_PLUS_EQ;
    endcase
    return k;
  endfunction

  // True for modes that hold a one-character operator awaiting lookahead.
  function automatic logic is_pending(lex_mode_t m);
    return (m == MODE_PLUS) || (m == MODE_MINUS) || (m == MODE_STAR) ||
           (m == MODE_SLASH) || (m == MODE_LT) || (m == MODE_GT);
  endfunction

endpackage

[design/olex_front.sv]
// ----------------------------------------------------------------------------
// Operator token lexer front
// Accepts characters and classifies each one before it enters the queue.
// ----------------------------------------------------------------------------
module olex_front (
  input  logic              in_push,
  output logic              in_full,
  input  olex_pkg::in_item_t in_item,
  input  logic              q_full,
  output olex_pkg::q_beat_t q_wr
);
  import olex_pkg::*;

  cls_item_t ci;
  logic [7:0] c;

  assign c = in_item.char_code;

  // Character decoder.
  always_comb begin
    ci.cls        = CLS_OTHER;
    ci.punct_kind = KIND_PLUS;
    ci.eos        = in_item.end_of_source;
    unique case (c)
      CH_PLUS:   ci.cls = CLS_PLUS;
      CH_MINUS:  ci.cls = CLS_MINUS;
      CH_STAR:   ci.cls = CLS_STAR;
      CH_SLASH:  ci.cls = CLS_SLASH;
      CH_LT:     ci.cls = CLS_LT;
      CH_GT:     ci.cls = CLS_GT;
      CH_EQ:     ci.cls = CLS_EQ;
      CH_QUOTE:  ci.cls = CLS_QUOTE;
      CH_DOT:    ci.cls = CLS_DOT;
      CH_COMMA:  begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_COMMA;     end
      CH_SEMI:   begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_SEMICOLON; end
      CH_COLON:  begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_COLON;     end
      CH_LPAREN: begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_LPAREN;    end
      CH_RPAREN: begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_RPAREN;    end
      CH_LSQ:    begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_LSQUARE;   end
      CH_RSQ:    begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_RSQUARE;   end
      CH_LCURLY: begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_LCURLY;    end
      CH_RCURLY: begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_RCURLY;    end
      CH_SPACE:  begin ci.cls = CLS_PUNCT; ci.punct_kind = KIND_SPACE;     end
      default: begin
        if (c >= CH_0 && c <= CH_9) begin
          ci.cls = CLS_DIGIT;
        end else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
                     c == CH_UNDER) begin
          ci.cls = CLS_ALPHA;
        end
      end
    endcase
  end

  // The front stalls only when the queue is full.
  assign in_full    = q_full;
  assign q_wr.valid = in_push && !q_full;
  assign q_wr.item  = ci;

endmodule

[design/olex_queue.sv]
// ----------------------------------------------------------------------------
// Operator token lexer queue
// Small FIFO of classified characters between the front and the back.
// ----------------------------------------------------------------------------
module olex_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  olex_pkg::q_beat_t q_wr,
  output logic              q_full,
  output olex_pkg::q_beat_t q_head,
  input  logic              q_pop
);
  import olex_pkg::*;

  cls_item_t       mem [QDEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            do_rd;

  assign q_full       = (count_r == (Q_AW+1)'(QDEPTH));
  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem[rd_ptr_r];
  assign do_rd        = q_pop && q_head.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_wr.valid) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_wr.valid && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (!q_wr.valid && do_rd) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (q_wr.valid) begin
      mem[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

[design/olex_back.sv]
// ----------------------------------------------------------------------------
// Operator token lexer back
// Runs the lexer mode machine on classified characters and hands out tokens.
// ----------------------------------------------------------------------------
module olex_back (
  input  logic                clk,
  input  logic                rst_n,
  input  olex_pkg::q_beat_t   q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output olex_pkg::out_item_t out_item
);
  import olex_pkg::*;

  typedef struct packed {
    tok_kind_t           kind;
    logic [POS_BITS-1:0] s;
    logic [POS_BITS-1:0] e;
  } tok_t;

  lex_mode_t           mode_r, mode_nxt, mode_mid;
  logic [POS_BITS-1:0] start_r, start_nxt, start_mid;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] last_r, last_nxt;
  logic [1:0]          sub_r, sub_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  cls_item_t           it;
  logic [POS_BITS-1:0] p, q;
  logic                consumed;
  tok_t                toks [3];
  logic [1:0]          n_tok;
  logic                load_tok, commit;

  assign it = q_head.item;
  assign p  = pos_r;
  assign q  = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  // Close the open token against the new character and start a new one.
  always_comb begin
    consumed  = 1'b0;
    mode_mid  = mode_r;
    start_mid = start_r;
    if (is_pending(mode_r)) begin
      consumed = (it.cls == CLS_EQ) ||
                 (mode_r == MODE_LT && it.cls == CLS_LT) ||
                 (mode_r == MODE_GT && it.cls == CLS_GT);
      mode_mid = MODE_IDLE;
    end else if (mode_r == MODE_NUMBER) begin
      consumed = (it.cls == CLS_DIGIT) || (it.cls == CLS_DOT);
      if (!consumed) mode_mid = MODE_IDLE;
    end else if (mode_r == MODE_IDENT) begin
      consumed = (it.cls == CLS_DIGIT) || (it.cls == CLS_ALPHA);
      if (!consumed) mode_mid = MODE_IDLE;
    end else if (mode_r == MODE_STRING) begin
      consumed = 1'b1;
      if (it.cls == CLS_QUOTE) mode_mid = MODE_IDLE;
    end
    if (!consumed) begin
      case (it.cls)
        CLS_PLUS:  begin mode_mid = MODE_PLUS;   start_mid = p; end
        CLS_MINUS: begin mode_mid = MODE_MINUS;  start_mid = p; end
        CLS_STAR:  begin mode_mid = MODE_STAR;   start_mid = p; end
        CLS_SLASH: begin mode_mid = MODE_SLASH;  start_mid = p; end
        CLS_LT:    begin mode_mid = MODE_LT;     start_mid = p; end
        CLS_GT:    begin mode_mid = MODE_GT;     start_mid = p; end
        CLS_QUOTE: begin mode_mid = MODE_STRING; start_mid = p; end
        CLS_DIGIT: begin mode_mid = MODE_NUMBER; start_mid = p; end
        CLS_ALPHA: begin mode_mid = MODE_IDENT;  start_mid = p; end
        default:   ;
      endcase
    end
  end

  // Next mode and positions; a source end returns everything to reset.
  always_comb begin
    if (it.eos) begin
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      pos_nxt   = '0;
      last_nxt  = '0;
    end else begin
      mode_nxt  = mode_mid;
      start_nxt = start_mid;
      pos_nxt   = q;
      last_nxt  = p;
    end
  end

  // Tokens caused by the head character, at most three.
  always_comb begin
    n_tok = '0;
    for (int i = 0; i < 3; i++) begin
      toks[i] = '{kind: KIND_PLUS, s: '0, e: '0};
    end
    // Closing of the token that was open before this character.
    if (is_pending(mode_r)) begin
      if (it.cls == CLS_EQ) begin
        toks[0] = '{kind: eq_kind(mode_r), s: start_r, e: p};
      end else if (mode_r == MODE_LT && it.cls == CLS_LT) begin
        toks[0] = '{kind: KIND_DBL_LANGLE, s: start_r, e: p};
      end else if (mode_r == MODE_GT && it.cls == CLS_GT) begin
        toks[0] = '{kind: KIND_DBL_RANGLE, s: start_r, e: p};
      end else begin
        toks[0] = '{kind: single_kind(mode_r), s: start_r, e: start_r};
      end
      n_tok = 2'd1;
    end else if (mode_r == MODE_NUMBER && !consumed) begin
      toks[0] = '{kind: KIND_NUMBER, s: start_r, e: last_r};
      n_tok   = 2'd1;
    end else if (mode_r == MODE_IDENT && !consumed) begin
      toks[0] = '{kind: KIND_IDENT, s: start_r, e: last_r};
      n_tok   = 2'd1;
    end else if (mode_r == MODE_STRING && it.cls == CLS_QUOTE) begin
      toks[0] = '{kind: KIND_STRING, s: start_r, e: p};
      n_tok   = 2'd1;
    end
    // Single-character tokens.
    if (!consumed && (it.cls == CLS_PUNCT || it.cls == CLS_DOT)) begin
      toks[n_tok] = '{kind: (it.cls == CLS_DOT) ? KIND_DOT : it.punct_kind, s: p, e: p};
      n_tok       = n_tok + 1'b1;
    end
    // Source end: flush the open token, then the end marker.
    if (it.eos) begin
      if (is_pending(mode_mid)) begin
        toks[n_tok] = '{kind: single_kind(mode_mid), s: start_mid, e: start_mid};
        n_tok       = n_tok + 1'b1;
      end else if (mode_mid == MODE_NUMBER) begin
        toks[n_tok] = '{kind: KIND_NUMBER, s: start_mid, e: p};
        n_tok       = n_tok + 1'b1;
      end else if (mode_mid == MODE_IDENT) begin
        toks[n_tok] = '{kind: KIND_IDENT, s: start_mid, e: p};
        n_tok       = n_tok + 1'b1;
      end else if (mode_mid == MODE_STRING) begin
        toks[n_tok] = '{kind: KIND_ERROR, s: start_mid, e: p};
        n_tok       = n_tok + 1'b1;
      end
      if (n_tok != 2'd3) begin
        toks[n_tok] = '{kind: KIND_EOF, s: q, e: q};
        n_tok       = n_tok + 1'b1;
      end
    end
  end

  // One token beat per cycle into the output register while it is empty or
  // popped; the character is retired together with its last token, if any.
  always_comb begin
    load_tok      = q_head.valid && (n_tok != 2'd0) && (!out_valid_r || out_pop);
    commit        = q_head.valid &&
                    ((n_tok == 2'd0) || (load_tok && (sub_r == n_tok - 1'b1)));
    q_pop         = commit;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (load_tok) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.token_kind     = toks[sub_r].kind;
      out_item_nxt.start_position = OUT_POS_W'(toks[sub_r].s);
      out_item_nxt.end_position   = OUT_POS_W'(toks[sub_r].e);
      out_item_nxt.last_of_run    = (sub_r == n_tok - 1'b1);
      sub_nxt                     = commit ? 2'd0 : sub_r + 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      start_r     <= '0;
      pos_r       <= '0;
      last_r      <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        mode_r  <= mode_nxt;
        start_r <= start_nxt;
        pos_r   <= pos_nxt;
        last_r  <= last_nxt;
      end
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/operator_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// Operator token lexer unit
// Streams source characters in and delivers operator, punctuation, number,
// identifier and string tokens with their start and end positions.
//
//   Channel  Handshake         Beat
//   in       in_push / in_full   one character with its end-of-source flag
//   out      out_pop / out_empty one token: kind, start, end, last-of-run
//
// A character with no token just retires; one with k tokens waits at the queue
// head while the back moves one token beat per cycle into the output register,
// when that is empty or popped. A four-entry queue of classified characters
// lets the front keep accepting while the back works or the output stalls.
// Reset is synchronous and clears the queue, lexer mode and positions.
// ----------------------------------------------------------------------------
module operator_token_lexer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  olex_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output olex_pkg::out_item_t out_item
);
  import olex_pkg::*;

  q_beat_t q_wr;
  q_beat_t q_head;
  logic    q_full;
  logic    q_pop;

  // Character classifier.
  olex_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  // Queue between front and back.
  olex_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Lexer mode machine and token output.
  olex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
